>>> hdl/mm_pkg.sv
`default_nettype none

package mm_pkg;

   // Transaction codes carried in the kind field
   localparam logic [1:0] KIND_LOAD_LEFT  = 2'd0;
   localparam logic [1:0] KIND_LOAD_RIGHT = 2'd1;
   localparam logic [1:0] KIND_MULTIPLY   = 2'd2;

   typedef struct packed {
      logic [1:0]         kind;
      logic [1:0]         row;
      logic [1:0]         col;
      logic signed [31:0] elem_value;
   } mm_req_type;

   typedef struct packed {
      logic [1:0]         out_row;
      logic [1:0]         out_col;
      logic signed [31:0] out_value;
      logic               last;
   } mm_rsp_type;

   // Travels with each operand pair down the MAC pipe
   typedef struct packed {
      logic       first;     // first term of a dot product
      logic       last_k;    // final term of a dot product
      logic       final_elem; // final element of the multiply
      logic [1:0] out_row;
      logic [1:0] out_col;
   } mm_tag_type;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_RUN   = 3'b010,
      ST_DRAIN = 3'b100
   } mm_state_type;

endpackage

`default_nettype wire

>>> hdl/mm_mac.sv
`default_nettype none

module mm_mac #(
   parameter int DIM       = 4,
   parameter int FRAC_BITS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               op_valid,
   input  wire logic signed [31:0] op_left,
   input  wire logic signed [31:0] op_right,
   input  wire mm_pkg::mm_tag_type op_tag,
   output      logic               rsp_valid,
   output      mm_pkg::mm_rsp_type rsp_data
);

   localparam int ACC_W = 64 + $clog2(DIM);

   // product stage
   logic                      prod_valid_ff;
   logic signed [63:0]        prod_ff;
   mm_pkg::mm_tag_type        prod_tag_ff;
   // accumulate stage
   logic                      acc_valid_ff;
   logic signed [ACC_W-1:0]   acc_ff;
   logic signed [ACC_W-1:0]   acc_in;
   logic signed [ACC_W-1:0]   prod_ext;
   mm_pkg::mm_tag_type        acc_tag_ff;
   // result stage
   logic signed [ACC_W-1:0]   acc_sh;
   logic                      fits;
   logic signed [31:0]        sat_value;
   logic                      rsp_valid_ff;
   mm_pkg::mm_rsp_type        rsp_ff;
   mm_pkg::mm_rsp_type        rsp_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff <= op_valid;
      end
      prod_ff     <= op_left * op_right;
      prod_tag_ff <= op_tag;
   end

   assign prod_ext = {{(ACC_W-64){prod_ff[63]}}, prod_ff};
   assign acc_in   = prod_tag_ff.first ? prod_ext : acc_ff + prod_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_valid_ff <= 1'b0;
      end else begin
         acc_valid_ff <= prod_valid_ff;
      end
      if (prod_valid_ff) begin
         acc_ff     <= acc_in;
         acc_tag_ff <= prod_tag_ff;
      end
   end

   // floor shift, then clamp to signed 32 bits
   assign acc_sh    = acc_ff >>> FRAC_BITS;
   assign fits      = (&acc_sh[ACC_W-1:31]) | ~(|acc_sh[ACC_W-1:31]);
   assign sat_value = fits ? acc_sh[31:0]
                    : (acc_sh[ACC_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff);

   always_comb begin
      rsp_in.out_row   = acc_tag_ff.out_row;
      rsp_in.out_col   = acc_tag_ff.out_col;
      rsp_in.out_value = sat_value;
      rsp_in.last      = acc_tag_ff.final_elem;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= acc_valid_ff & acc_tag_ff.last_k;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

>>> hdl/matrix_multiply_4x4_top.sv
`default_nettype none

// DIM x DIM signed fixed-point matrix multiplier (Q(31-FRAC_BITS).FRAC_BITS).
// Load transactions (kind 0 left, kind 1 right) write one element each and
// are taken every cycle while busy is low; they produce no result and never
// raise busy. Loads with row or col not below DIM, and kind 3, are dropped
// silently. A multiply transaction (kind 2) raises busy until its final
// result is out: a single multiply-accumulate unit walks every (row, col, k)
// triple, one per cycle, fed by one read port on each element memory, then a
// four-stage pipe (memory read, product, accumulate, shift/saturate) drains.
// Results appear on rsp_data for exactly one cycle each, flagged by
// rsp_valid, in row-major order, with last set on the final element. There is
// no back-pressure on the result side: the receiver must take every strobe.
// Each sum of DIM full-width products is floored by FRAC_BITS and clamped to
// signed 32 bits. Elements hold no reset value; read only what was loaded.

module matrix_multiply_4x4_top #(
   parameter int DIM       = 4,
   parameter int FRAC_BITS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output      logic               busy,
   input  wire mm_pkg::mm_req_type req_data,
   output      logic               rsp_valid,
   output      mm_pkg::mm_rsp_type rsp_data
);

   localparam int NUM_ELEMS = DIM * DIM;
   localparam int ADDR_W    = $clog2(NUM_ELEMS);
   localparam int IDX_W     = $clog2(DIM);
   localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(DIM - 1);

   // element stores, one read port each
   logic [31:0] left_mem  [NUM_ELEMS];
   logic [31:0] right_mem [NUM_ELEMS];

   mm_pkg::mm_state_type state_ff, state_in;
   logic [IDX_W-1:0]     row_ff, row_in;
   logic [IDX_W-1:0]     col_ff, col_in;
   logic [IDX_W-1:0]     k_ff, k_in;

   logic                 accept;
   logic                 load_ok;
   logic [ADDR_W-1:0]    wr_addr;
   logic                 issue;
   logic                 issue_done;
   logic [ADDR_W-1:0]    left_addr;
   logic [ADDR_W-1:0]    right_addr;
   mm_pkg::mm_tag_type   issue_tag;

   // read stage
   logic                 rd_valid_ff;
   logic signed [31:0]   left_rd_ff;
   logic signed [31:0]   right_rd_ff;
   mm_pkg::mm_tag_type   rd_tag_ff;

   assign busy    = (state_ff != mm_pkg::ST_IDLE);
   assign accept  = start & ~busy;
   assign load_ok = (int'(req_data.row) < DIM) && (int'(req_data.col) < DIM);
   assign wr_addr = ADDR_W'(int'(req_data.row) * DIM + int'(req_data.col));

   // element writes: only while idle, so never clash with the read walk
   always_ff @(posedge clock) begin
      if (accept && load_ok && req_data.kind == mm_pkg::KIND_LOAD_LEFT) begin
         left_mem[wr_addr] <= req_data.elem_value;
      end
      if (accept && load_ok && req_data.kind == mm_pkg::KIND_LOAD_RIGHT) begin
         right_mem[wr_addr] <= req_data.elem_value;
      end
   end

   // sequencer over (row, col, k)
   assign issue      = (state_ff == mm_pkg::ST_RUN);
   assign issue_done = (row_ff == IDX_MAX) && (col_ff == IDX_MAX) && (k_ff == IDX_MAX);
   assign left_addr  = ADDR_W'(int'(row_ff) * DIM + int'(k_ff));
   assign right_addr = ADDR_W'(int'(k_ff) * DIM + int'(col_ff));

   always_comb begin
      issue_tag.first      = (k_ff == '0);
      issue_tag.last_k     = (k_ff == IDX_MAX);
      issue_tag.final_elem = (row_ff == IDX_MAX) && (col_ff == IDX_MAX);
      issue_tag.out_row    = 2'(row_ff);
      issue_tag.out_col    = 2'(col_ff);
   end

   always_comb begin
      state_in = state_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      k_in     = k_ff;
      unique case (state_ff)
         mm_pkg::ST_IDLE: begin
            row_in = '0;
            col_in = '0;
            k_in   = '0;
            if (accept && req_data.kind == mm_pkg::KIND_MULTIPLY) begin
               state_in = mm_pkg::ST_RUN;
            end
         end
         mm_pkg::ST_RUN: begin
            if (k_ff == IDX_MAX) begin
               k_in = '0;
               if (col_ff == IDX_MAX) begin
                  col_in = '0;
                  row_in = row_ff + 1'b1;
               end else begin
                  col_in = col_ff + 1'b1;
               end
            end else begin
               k_in = k_ff + 1'b1;
            end
            if (issue_done) begin
               state_in = mm_pkg::ST_DRAIN;
            end
         end
         mm_pkg::ST_DRAIN: begin
            if (rsp_valid && rsp_data.last) begin
               state_in = mm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mm_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= mm_pkg::ST_IDLE;
         row_ff      <= '0;
         col_ff      <= '0;
         k_ff        <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
         k_ff        <= k_in;
         rd_valid_ff <= issue;
      end
   end

   // registered memory reads, tag kept in step
   always_ff @(posedge clock) begin
      if (issue) begin
         left_rd_ff  <= left_mem[left_addr];
         right_rd_ff <= right_mem[right_addr];
         rd_tag_ff   <= issue_tag;
      end
   end

   mm_mac #(
      .DIM       (DIM),
      .FRAC_BITS (FRAC_BITS)
   ) u_mac (
      .clock     (clock),
      .reset     (reset),
      .op_valid  (rd_valid_ff),
      .op_left   (left_rd_ff),
      .op_right  (right_rd_ff),
      .op_tag    (rd_tag_ff),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // results only come out of a multiply in flight
   a_rsp_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe while idle");

   // the final element releases the block
   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.last) |=> !busy)
      else $error("busy held after final element");

   // a multiply transaction always starts the walk
   a_mult_starts: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.kind == mm_pkg::KIND_MULTIPLY) |=> issue)
      else $error("multiply accepted but walk not started");

   // read stage is empty whenever the block is idle
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      !busy |-> !rd_valid_ff)
      else $error("operands in flight while idle");

endmodule

`default_nettype wire
